@@ rtl/core/segment_rect_overlap_test_unit_macros.svh @@
// assertion macros for the segment / rectangle overlap test unit
// no dependencies; included by the files that carry concurrent checks
`ifndef SEGMENT_RECT_OVERLAP_TEST_UNIT_MACROS_SVH
`define SEGMENT_RECT_OVERLAP_TEST_UNIT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every edge outside reset
`define SROT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in this cycle implies expression in the next one
`define SROT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`else

`define SROT_ASSERT(label, clk, rst, prop, msg)

`define SROT_ASSERT_NEXT(label, clk, rst, cond, expr, msg)

`endif

`endif

@@ rtl/core/srot_pkg.sv @@
// shared types for the segment / rectangle overlap test unit
// no dependencies
package srot_pkg;

  // rectangle sides, in test order
  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_t;

  localparam int NUM_SIDES = 4;

endpackage

@@ rtl/core/segment_rect_overlap_test_unit.sv @@
// segment / rectangle overlap test, pipelined from request accept to result valid
// throughput one request per cycle unless the result side stalls; four register stages plus the result register,
// each advancing on its own so bubbles collapse while the result side stalls
// rst (synchronous, active high) clears the valid bits of all stages; payload is not reset
// depends on srot_pkg and segment_rect_overlap_test_unit_macros.svh
`include "segment_rect_overlap_test_unit_macros.svh"

module segment_rect_overlap_test_unit #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  input  logic signed [COORD_WIDTH-1:0] box_left,
  input  logic signed [COORD_WIDTH-1:0] box_top,
  input  logic signed [COORD_WIDTH-1:0] box_width,
  input  logic signed [COORD_WIDTH-1:0] box_height,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          overlaps
);

  // edge coordinates and coordinate differences need one extra bit,
  // the numerator along the segment two, the cross products the rest
  localparam int AW = COORD_WIDTH + 1;
  localparam int NW = COORD_WIDTH + 2;
  localparam int PW = 2 * COORD_WIDTH + 4;
  localparam int NS = srot_pkg::NUM_SIDES;

  // ---------------------------------------------------------------------------
  // per-side operand selection
  // top / bottom: across axis is y, edge runs along x from box_left over box_width
  // left / right: across axis is x, edge runs along y from box_top over box_height
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0]          side_c   [NS];  // edge line position on across axis
  logic signed [COORD_WIDTH-1:0] side_sa  [NS];  // segment start, across
  logic signed [COORD_WIDTH-1:0] side_ea  [NS];  // segment end, across
  logic signed [COORD_WIDTH-1:0] side_sb  [NS];  // segment start, along
  logic signed [COORD_WIDTH-1:0] side_eb  [NS];  // segment end, along
  logic signed [COORD_WIDTH-1:0] side_e0  [NS];  // edge start, along
  logic signed [COORD_WIDTH-1:0] side_len [NS];  // edge length, signed

  always_comb begin
    side_c[srot_pkg::SIDE_TOP]    = AW'(box_top);
    side_c[srot_pkg::SIDE_BOTTOM] = AW'(box_top) + AW'(box_height);
    side_c[srot_pkg::SIDE_LEFT]   = AW'(box_left);
    side_c[srot_pkg::SIDE_RIGHT]  = AW'(box_left) + AW'(box_width);

    side_sa[srot_pkg::SIDE_TOP]    = seg_start_y;
    side_sa[srot_pkg::SIDE_BOTTOM] = seg_start_y;
    side_sa[srot_pkg::SIDE_LEFT]   = seg_start_x;
    side_sa[srot_pkg::SIDE_RIGHT]  = seg_start_x;

    side_ea[srot_pkg::SIDE_TOP]    = seg_end_y;
    side_ea[srot_pkg::SIDE_BOTTOM] = seg_end_y;
    side_ea[srot_pkg::SIDE_LEFT]   = seg_end_x;
    side_ea[srot_pkg::SIDE_RIGHT]  = seg_end_x;

    side_sb[srot_pkg::SIDE_TOP]    = seg_start_x;
    side_sb[srot_pkg::SIDE_BOTTOM] = seg_start_x;
    side_sb[srot_pkg::SIDE_LEFT]   = seg_start_y;
    side_sb[srot_pkg::SIDE_RIGHT]  = seg_start_y;

    side_eb[srot_pkg::SIDE_TOP]    = seg_end_x;
    side_eb[srot_pkg::SIDE_BOTTOM] = seg_end_x;
    side_eb[srot_pkg::SIDE_LEFT]   = seg_end_y;
    side_eb[srot_pkg::SIDE_RIGHT]  = seg_end_y;

    side_e0[srot_pkg::SIDE_TOP]    = box_left;
    side_e0[srot_pkg::SIDE_BOTTOM] = box_left;
    side_e0[srot_pkg::SIDE_LEFT]   = box_top;
    side_e0[srot_pkg::SIDE_RIGHT]  = box_top;

    side_len[srot_pkg::SIDE_TOP]    = box_width;
    side_len[srot_pkg::SIDE_BOTTOM] = box_width;
    side_len[srot_pkg::SIDE_LEFT]   = box_height;
    side_len[srot_pkg::SIDE_RIGHT]  = box_height;
  end

  // ---------------------------------------------------------------------------
  // stage registers, one lane per side
  // ---------------------------------------------------------------------------
  // stage 1: edge position and raw differences
  logic                          s1_valid;
  logic signed [AW-1:0]          s1_c   [NS];
  logic signed [COORD_WIDTH-1:0] s1_sa  [NS];
  logic signed [AW-1:0]          s1_d1  [NS];  // segment extent across
  logic signed [AW-1:0]          s1_off [NS];  // segment start minus edge start, along
  logic signed [AW-1:0]          s1_dlt [NS];  // segment extent along
  logic signed [COORD_WIDTH-1:0] s1_len [NS];

  // stage 2: numerator and extent across, folded so the extent is positive
  logic                          s2_valid;
  logic signed [NW-1:0]          s2_n1   [NS];
  logic signed [NW-1:0]          s2_d1   [NS];
  logic signed [AW-1:0]          s2_off  [NS];
  logic signed [AW-1:0]          s2_dlt  [NS];
  logic signed [COORD_WIDTH-1:0] s2_len  [NS];
  logic                          s2_zero [NS];  // zero extent on either side

  // stage 3: cross products and early reject
  logic                 s3_valid;
  logic signed [PW-1:0] s3_p1  [NS];
  logic signed [PW-1:0] s3_p2  [NS];
  logic signed [PW-1:0] s3_den [NS];
  logic                 s3_rej [NS];
  logic                 s3_neg [NS];  // edge runs the negative way

  // stage 4: along-edge numerator
  logic                 s4_valid;
  logic signed [PW-1:0] s4_num [NS];
  logic signed [PW-1:0] s4_den [NS];
  logic                 s4_rej [NS];
  logic                 s4_neg [NS];

  // ---------------------------------------------------------------------------
  // flow control: a stage loads when it is empty or its successor moves on
  // ---------------------------------------------------------------------------
  logic adv_res;
  logic adv_s4;
  logic adv_s3;
  logic adv_s2;
  logic adv_s1;

  assign adv_res   = !res_valid || !res_stall;
  assign adv_s4    = !s4_valid || adv_res;
  assign adv_s3    = !s3_valid || adv_s4;
  assign adv_s2    = !s2_valid || adv_s3;
  assign adv_s1    = !s1_valid || adv_s2;
  assign req_stall = !adv_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid <= req_valid;
      end
      if (adv_s2) begin
        s2_valid <= s1_valid;
      end
      if (adv_s3) begin
        s3_valid <= s2_valid;
      end
      if (adv_s4) begin
        s4_valid <= s3_valid;
      end
      if (adv_res) begin
        res_valid <= s4_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  logic [NS-1:0] side_hit;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      // stage 1: edge position and segment differences
      if (adv_s1) begin
        s1_c[i]   <= side_c[i];
        s1_sa[i]  <= side_sa[i];
        s1_d1[i]  <= AW'(side_ea[i]) - AW'(side_sa[i]);
        s1_off[i] <= AW'(side_sb[i]) - AW'(side_e0[i]);
        s1_dlt[i] <= AW'(side_eb[i]) - AW'(side_sb[i]);
        s1_len[i] <= side_len[i];
      end
      // stage 2: flip signs so the extent across is positive
      if (adv_s2) begin
        if (s1_d1[i][AW-1]) begin
          s2_n1[i] <= NW'(s1_sa[i]) - NW'(s1_c[i]);
          s2_d1[i] <= -NW'(s1_d1[i]);
        end else begin
          s2_n1[i] <= NW'(s1_c[i]) - NW'(s1_sa[i]);
          s2_d1[i] <= NW'(s1_d1[i]);
        end
        s2_off[i]  <= s1_off[i];
        s2_dlt[i]  <= s1_dlt[i];
        s2_len[i]  <= s1_len[i];
        s2_zero[i] <= (s1_d1[i] == '0) || (s1_len[i] == '0);
      end
      // stage 3: cross products, segment parameter range check alongside
      if (adv_s3) begin
        s3_p1[i]  <= PW'(s2_off[i]) * PW'(s2_d1[i]);
        s3_p2[i]  <= PW'(s2_n1[i]) * PW'(s2_dlt[i]);
        s3_den[i] <= PW'(s2_d1[i]) * PW'(s2_len[i]);
        s3_rej[i] <= s2_zero[i] || s2_n1[i][NW-1] || (s2_n1[i] > s2_d1[i]);
        s3_neg[i] <= s2_len[i][COORD_WIDTH-1];
      end
      // stage 4: position along the edge, scaled by extent across
      if (adv_s4) begin
        s4_num[i] <= s3_p1[i] + s3_p2[i];
        s4_den[i] <= s3_den[i];
        s4_rej[i] <= s3_rej[i];
        s4_neg[i] <= s3_neg[i];
      end
    end
    if (adv_res) begin
      overlaps <= |side_hit;
    end
  end

  // edge parameter in 0..1: num between 0 and den, bounds swap for a negative edge
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (s4_neg[i]) begin
        side_hit[i] = !s4_rej[i] && (s4_num[i][PW-1] || (s4_num[i] == '0))
                      && (s4_den[i] <= s4_num[i]);
      end else begin
        side_hit[i] = !s4_rej[i] && !s4_num[i][PW-1] && (s4_num[i] <= s4_den[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the request side only stalls once every stage and the result register hold an item and the result side stalls
  `SROT_ASSERT(a_stall_only_when_full, clk, rst,
               !req_stall || (s1_valid && s2_valid && s3_valid && s4_valid
                              && res_valid && res_stall),
               "request stalled with room in the pipeline")
  // an item leaving the last stage lands in the result register
  `SROT_ASSERT_NEXT(a_s4_to_result, clk, rst, s4_valid && adv_res, res_valid,
                    "item lost between last stage and result")
  // when every side is rejected the result must be a miss
  `SROT_ASSERT_NEXT(a_reject_gives_miss, clk, rst,
                    s4_valid && adv_res && s4_rej[0] && s4_rej[1] && s4_rej[2] && s4_rej[3],
                    !overlaps, "overlap reported with every side rejected")

endmodule

@@ tb/sv/tb_segment_rect_overlap_test_unit.sv @@
// self-checking testbench for segment_rect_overlap_test_unit: directed and random requests
// against an in-bench exact predictor, with random gaps and stalls on both channels
// depends on srot_pkg and the segment_rect_overlap_test_unit rtl
`timescale 1ns / 1ps

module tb_segment_rect_overlap_test_unit;

  localparam int CW        = 24;
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;
  localparam int RAND_REQS = 850;

  // one request as the driver sees it; drain_first holds it back until
  // every result already owed has come out
  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey, left, top, w, h;
    bit                   drain_first;
  } seg_box_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic signed [CW-1:0] seg_start_x = '0;
  logic signed [CW-1:0] seg_start_y = '0;
  logic signed [CW-1:0] seg_end_x   = '0;
  logic signed [CW-1:0] seg_end_y   = '0;
  logic signed [CW-1:0] box_left    = '0;
  logic signed [CW-1:0] box_top     = '0;
  logic signed [CW-1:0] box_width   = '0;
  logic signed [CW-1:0] box_height  = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic                 overlaps;

  seg_box_req_t pending[$];           // requests not yet presented
  bit           overlap_expected[$];  // predicted overlap flags, oldest first
  seg_box_req_t cur_req;              // request currently on the request ports
  int           mismatch_count = 0;

  // pacing state of the two channels
  int send_gap = 0, send_calm = 0;
  int hold_left = 0, hold_calm = 0;

  segment_rect_overlap_test_unit #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y),
    .seg_end_x  (seg_end_x),
    .seg_end_y  (seg_end_y),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .overlaps   (overlaps)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one edge at line_pos on the "across" axis, starting at edge_start on the
  // other axis with signed length edge_len; a0/a1 segment across, b0/b1 along.
  // every quantity fits easily in 64 bits, so the ratios t1 and t2 are
  // range-checked exactly by cross-multiplying
  function automatic bit edge_crossed(longint line_pos, longint a0, longint a1,
                                      longint b0, longint b1,
                                      longint edge_start, longint edge_len);
    longint n1, d1, num, den;
    n1 = line_pos - a0;
    d1 = a1 - a0;
    // segment parallel to the edge, or edge of zero length: no hit
    if (d1 == 0 || edge_len == 0) return 1'b0;
    if (d1 < 0) begin
      n1 = -n1;
      d1 = -d1;
    end
    // t1 = n1 / d1 outside 0..1
    if (n1 < 0 || n1 > d1) return 1'b0;
    // t2 * d1 * edge_len, measured from the edge start
    num = (b0 - edge_start) * d1 + n1 * (b1 - b0);
    den = d1 * edge_len;
    // a negative extent flips the sense of the range check
    if (edge_len > 0) return num >= 0 && num <= den;
    return num <= 0 && den <= num;
  endfunction

  // sides in test order; edge coordinates are full precision, no wrap
  function automatic bit predict_overlap(seg_box_req_t q);
    longint           sx, sy, ex, ey, l, t, w, h;
    srot_pkg::side_t  side;
    bit               hit;
    sx = q.sx;
    sy = q.sy;
    ex = q.ex;
    ey = q.ey;
    l  = q.left;
    t  = q.top;
    w  = q.w;
    h  = q.h;
    hit = 1'b0;
    for (int s = 0; s < srot_pkg::NUM_SIDES; s++) begin
      side = srot_pkg::side_t'(s);
      case (side)
        srot_pkg::SIDE_TOP:    hit |= edge_crossed(t,     sy, ey, sx, ex, l, w);
        srot_pkg::SIDE_BOTTOM: hit |= edge_crossed(t + h, sy, ey, sx, ex, l, w);
        srot_pkg::SIDE_LEFT:   hit |= edge_crossed(l,     sx, ex, sy, ey, t, h);
        srot_pkg::SIDE_RIGHT:  hit |= edge_crossed(l + w, sx, ex, sy, ey, t, h);
      endcase
    end
    return hit;
  endfunction

  // idle length for one channel: mostly none or short, a few long, and now
  // and then a calm stretch with no idling at all
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic seg_box_req_t make_req(int sx, int sy, int ex, int ey,
                                            int l, int t, int w, int h);
    seg_box_req_t q;
    q.sx = CW'(sx);
    q.sy = CW'(sy);
    q.ex = CW'(ex);
    q.ey = CW'(ey);
    q.left = CW'(l);
    q.top = CW'(t);
    q.w = CW'(w);
    q.h = CW'(h);
    q.drain_first = 1'b0;
    return q;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      3: return COORD_MAX - span(0, 64);
      default: return COORD_MIN + span(0, 64);
    endcase
  endfunction

  // random request; most are segments placed around the rectangle so that
  // crossings, touches and near misses are common
  function automatic seg_box_req_t gen_req();
    seg_box_req_t q;
    int r, bx, by, l, t, w, h, m, px, py, qx, qy, lo_x, hi_x, lo_y, hi_y;
    r  = $urandom_range(0, 99);
    bx = span(-4194304, 4194304);
    by = span(-4194304, 4194304);
    if (r < 12) begin
      // noise over the full field range
      q = make_req($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
    end else if (r < 20) begin
      // field extremes, edge sums past the field range
      q = make_req(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                   pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end else if (r < 35) begin
      // tiny grid: exact touches at t = 0 and t = 1 are frequent
      q = make_req(bx + span(-6, 6), by + span(-6, 6), bx + span(-6, 6), by + span(-6, 6),
                   bx + span(-4, 4), by + span(-4, 4), span(-6, 6), span(-6, 6));
    end else begin
      m = ($urandom_range(0, 3) == 0) ? 40 : 3000;
      w = ($urandom_range(0, 19) == 0) ? 0 : span(-m, m);
      h = ($urandom_range(0, 19) == 0) ? 0 : span(-m, m);
      l = bx;
      t = by;
      lo_x = l + ((w < 0) ? w : 0) - m / 2;
      hi_x = l + ((w > 0) ? w : 0) + m / 2;
      lo_y = t + ((h < 0) ? h : 0) - m / 2;
      hi_y = t + ((h > 0) ? h : 0) + m / 2;
      px = span(lo_x, hi_x);
      py = span(lo_y, hi_y);
      qx = span(lo_x, hi_x);
      qy = span(lo_y, hi_y);
      if (r >= 75 && r < 90) begin
        // one endpoint exactly on an edge (corners included)
        case ($urandom_range(0, 3))
          0: begin px = l + span((w < 0) ? w : 0, (w > 0) ? w : 0); py = t;     end
          1: begin px = l + span((w < 0) ? w : 0, (w > 0) ? w : 0); py = t + h; end
          2: begin py = t + span((h < 0) ? h : 0, (h > 0) ? h : 0); px = l;     end
          default: begin
            py = t + span((h < 0) ? h : 0, (h > 0) ? h : 0);
            px = l + w;
          end
        endcase
      end else if (r >= 90) begin
        // segment lying on an edge line: zero extent across that edge
        case ($urandom_range(0, 3))
          0: begin py = t;     qy = t;     end
          1: begin py = t + h; qy = t + h; end
          2: begin px = l;     qx = l;     end
          default: begin px = l + w; qx = l + w; end
        endcase
      end
      if ($urandom_range(0, 1))
        q = make_req(px, py, qx, qy, l, t, w, h);
      else
        q = make_req(qx, qy, px, py, l, t, w, h);
    end
    return q;
  endfunction

  // request driver: a new request goes out only once the previous one was taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      // request taken at this edge: predict its result now
      if (req_valid && !req_stall)
        overlap_expected.push_back(predict_overlap(cur_req));
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain_first && overlap_expected.size() != 0)) begin
          cur_req = pending.pop_front();
          seg_start_x <= cur_req.sx;
          seg_start_y <= cur_req.sy;
          seg_end_x   <= cur_req.ex;
          seg_end_y   <= cur_req.ey;
          box_left    <= cur_req.left;
          box_top     <= cur_req.top;
          box_width   <= cur_req.w;
          box_height  <= cur_req.h;
          req_valid   <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          // nothing to send, or holding off until the pipe drains
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and result-side stall
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (overlap_expected.size() == 0) begin
          $display("%0t: result with nothing owed: expected none, got overlaps=%0b",
                   $time, overlaps);
          mismatch_count++;
        end else if (overlaps !== overlap_expected[0]) begin
          $display("%0t: overlaps mismatch: expected %0b, got %0b",
                   $time, overlap_expected[0], overlaps);
          mismatch_count++;
          void'(overlap_expected.pop_front());
        end else begin
          void'(overlap_expected.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        hold_left = pick_gap(hold_calm);
      end
    end
  end

  // stimulus and end of run
  initial begin
    seg_box_req_t q;
    // directed: default box is left 0, top 0, width 20, height 30
    pending.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(make_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    pending.push_back(make_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    pending.push_back(make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                               COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    pending.push_back(make_req(10, -10, 10, 10, 0, 0, 20, 30));   // crosses top
    pending.push_back(make_req(10, 25, 10, 35, 0, 0, 20, 30));    // crosses bottom
    pending.push_back(make_req(-5, 10, 5, 10, 0, 0, 20, 30));     // crosses left
    pending.push_back(make_req(15, 10, 25, 10, 0, 0, 20, 30));    // crosses right
    pending.push_back(make_req(5, 5, 10, 10, 0, 0, 20, 30));      // fully inside
    pending.push_back(make_req(30, 40, 50, 60, 0, 0, 20, 30));    // fully outside
    pending.push_back(make_req(5, -5, 5, 0, 0, 0, 20, 30));       // end touches top
    pending.push_back(make_req(-5, -5, 0, 0, 0, 0, 20, 30));      // touches a corner
    pending.push_back(make_req(5, 0, 15, 0, 0, 0, 20, 30));       // lies on top line
    pending.push_back(make_req(-1, -5, -1, 5, 0, 0, 20, 30));     // misses by one lsb
    pending.push_back(make_req(20, -5, 20, 5, 0, 0, 20, 30));     // hits far top corner
    pending.push_back(make_req(0, -5, 0, 5, 0, 0, 0, 30));        // zero width
    pending.push_back(make_req(-5, 0, 5, 0, 0, 0, 20, 0));        // zero height
    pending.push_back(make_req(10, -10, 10, 10, 20, 0, -20, 30)); // negative width
    pending.push_back(make_req(-5, 10, 5, 10, 0, 30, 20, -30));   // negative height
    pending.push_back(make_req(10, 10, 10, -10, 0, 0, 20, 30));   // reversed segment
    // edges past the field range
    pending.push_back(make_req(COORD_MAX - 5, COORD_MAX - 20, COORD_MAX - 5, COORD_MAX,
                               COORD_MAX - 10, COORD_MAX - 10, COORD_MAX, COORD_MAX));
    // fractional q16.8 coordinates
    pending.push_back(make_req(32'h80, -32'sh100, 32'h180, 32'h100, 0, 0, 32'h100, 32'h100));

    // random part; some requests wait for the pipe to empty first
    for (int i = 0; i < RAND_REQS; i++) begin
      q = gen_req();
      q.drain_first = (i % 200 == 0);
      pending.push_back(q);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // everything sent and every owed result seen
    while (pending.size() != 0 || req_valid || overlap_expected.size() != 0)
      @(posedge clk);
    // then wait on to catch stray results
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
